// ===== src/obbsat_pkg.sv =====
// Shared constants for the oriented box overlap pipeline.
// No dependencies.
package obbsat_pkg;
    localparam int NUM_FACE   = 6;
    localparam int NUM_CROSS  = 9;
    localparam int NUM_AXES   = NUM_FACE + NUM_CROSS;
    localparam int NUM_STAGES = 8;
endpackage

// ===== src/obbsat_in_if.sv =====
// Input channel: one box pair per word, valid/ready handshake.
// No dependencies.
interface obbsat_in_if #(parameter int W = 63);
    logic         valid;
    logic         ready;
    logic [W-1:0] a_center;
    logic [W-1:0] a_axis_right;
    logic [W-1:0] a_axis_up;
    logic [W-1:0] a_axis_forward;
    logic [W-1:0] a_half_extent;
    logic [W-1:0] b_center;
    logic [W-1:0] b_axis_right;
    logic [W-1:0] b_axis_up;
    logic [W-1:0] b_axis_forward;
    logic [W-1:0] b_half_extent;
    modport source (output valid, a_center, a_axis_right, a_axis_up, a_axis_forward,
                    a_half_extent, b_center, b_axis_right, b_axis_up, b_axis_forward,
                    b_half_extent, input ready);
    modport sink (input valid, a_center, a_axis_right, a_axis_up, a_axis_forward,
                  a_half_extent, b_center, b_axis_right, b_axis_up, b_axis_forward,
                  b_half_extent, output ready);
endinterface

// ===== src/obbsat_out_if.sv =====
// Output channel: one overlap flag per word, valid/ready handshake.
// No dependencies.
interface obbsat_out_if;
    logic valid;
    logic ready;
    logic overlap;
    modport source (output valid, overlap, input ready);
    modport sink (input valid, overlap, output ready);
endinterface

// ===== src/obb_obb_separating_axis_test.sv =====
// Oriented box pair overlap test, 15 separating axes, eight-stage pipeline.
// Depends on obbsat_pkg, obbsat_in_if, obbsat_out_if.
//
//   channel | dir | payload                                   | handshake
//   i_in    | in  | two boxes: center, three axes, half sizes | valid/ready
//   o_out   | out | overlap flag                              | valid/ready
//
// One word is taken per cycle unless the output stalls with every stage full.
// Stages: unpack, cross products, cross axes, dot products, round, scale, compare, output.
// Synchronous active-low reset clears the stage valid bits only.
// Each stage advances when empty or when the next stage advances, so bubbles close up
// and input is taken while a result waits at the output if any stage is empty.
module obb_obb_separating_axis_test #(
    parameter int COMPONENT_BITS = 21
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    obbsat_in_if.sink     i_in,
    obbsat_out_if.source  o_out
);
    localparam int C    = COMPONENT_BITS;
    localparam int DW   = C + 1;
    localparam int LW   = C + 3;
    localparam int PW   = 2 * C;
    localparam int DDW  = DW + LW + 2;
    localparam int ADW  = C + LW + 2;
    localparam int RW   = LW + 4;
    localparam int TW   = RW + C;
    localparam int SW   = TW + 3;
    localparam int NA   = obbsat_pkg::NUM_AXES;
    localparam int NF   = obbsat_pkg::NUM_FACE;
    localparam int NC   = obbsat_pkg::NUM_CROSS;
    localparam int NS   = obbsat_pkg::NUM_STAGES;
    localparam logic signed [PW+1:0] CRND = (PW + 2)'(1) <<< (C - 3);
    localparam logic [ADW:0]         ARND = (ADW + 1)'(1) << (C - 3);

    logic [NS:1] r_vld;
    logic [NS:1] adv;

    always_comb begin
        adv[NS] = !r_vld[NS] || o_out.ready;
        for (int k = NS - 1; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign i_in.ready  = adv[1];
    assign o_out.valid = r_vld[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[1]) begin
                r_vld[1] <= i_in.valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: unpack
    logic [3*C-1:0]      w_ax  [NF];
    logic [3*C-1:0]      w_h   [2];
    logic signed [C-1:0] n1_ax [NF][3];
    logic signed [DW-1:0] n1_d [3];
    logic [C-1:0]        n1_h  [NF];
    logic                n1_same;
    logic signed [C:0]   w_hx  [NF];
    logic signed [C:0]   w_ha  [NF];

    always_comb begin
        w_ax[0] = i_in.a_axis_right[3*C-1:0];
        w_ax[1] = i_in.a_axis_up[3*C-1:0];
        w_ax[2] = i_in.a_axis_forward[3*C-1:0];
        w_ax[3] = i_in.b_axis_right[3*C-1:0];
        w_ax[4] = i_in.b_axis_up[3*C-1:0];
        w_ax[5] = i_in.b_axis_forward[3*C-1:0];
        w_h[0]  = i_in.a_half_extent[3*C-1:0];
        w_h[1]  = i_in.b_half_extent[3*C-1:0];
        for (int n = 0; n < NF; n++) begin
            for (int c = 0; c < 3; c++) begin
                n1_ax[n][c] = signed'(w_ax[n][c*C +: C]);
            end
        end
        for (int c = 0; c < 3; c++) begin
            n1_d[c] = DW'(signed'(i_in.b_center[c*C +: C]))
                    - DW'(signed'(i_in.a_center[c*C +: C]));
        end
        for (int n = 0; n < NF; n++) begin
            w_hx[n] = (C + 1)'(signed'(w_h[n / 3][(n % 3)*C +: C]));
            w_ha[n] = w_hx[n][C] ? -w_hx[n] : w_hx[n];
            n1_h[n] = w_ha[n][C-1:0];
        end
        n1_same = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (w_ax[i] == w_ax[3+j]) begin
                    n1_same = 1'b1;
                end
            end
        end
    end

    logic signed [C-1:0]  r1_ax [NF][3];
    logic signed [DW-1:0] r1_d  [3];
    logic [C-1:0]         r1_h  [NF];
    logic                 r1_same;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_ax   <= n1_ax;
            r1_d    <= n1_d;
            r1_h    <= n1_h;
            r1_same <= n1_same;
        end
    end

    // stage 2: cross component products
    logic signed [PW-1:0] n2_p [NC][6];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n2_p[i*3+j][0] = PW'(r1_ax[i][1] * r1_ax[3+j][2]);
                n2_p[i*3+j][1] = PW'(r1_ax[i][2] * r1_ax[3+j][1]);
                n2_p[i*3+j][2] = PW'(r1_ax[i][2] * r1_ax[3+j][0]);
                n2_p[i*3+j][3] = PW'(r1_ax[i][0] * r1_ax[3+j][2]);
                n2_p[i*3+j][4] = PW'(r1_ax[i][0] * r1_ax[3+j][1]);
                n2_p[i*3+j][5] = PW'(r1_ax[i][1] * r1_ax[3+j][0]);
            end
        end
    end

    logic signed [PW-1:0] r2_p  [NC][6];
    logic signed [C-1:0]  r2_ax [NF][3];
    logic signed [DW-1:0] r2_d  [3];
    logic [C-1:0]         r2_h  [NF];
    logic                 r2_same;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_p    <= n2_p;
            r2_ax   <= r1_ax;
            r2_d    <= r1_d;
            r2_h    <= r1_h;
            r2_same <= r1_same;
        end
    end

    // stage 3: test axes, cross components rounded
    logic signed [LW-1:0] n3_l  [NA][3];
    logic signed [PW+1:0] w_df  [NC][3];
    logic signed [PW+1:0] w_sh  [NC][3];

    always_comb begin
        for (int n = 0; n < NF; n++) begin
            for (int c = 0; c < 3; c++) begin
                n3_l[n][c] = LW'(r2_ax[n][c]);
            end
        end
        for (int m = 0; m < NC; m++) begin
            for (int c = 0; c < 3; c++) begin
                w_df[m][c] = (PW + 2)'(r2_p[m][2*c]) - (PW + 2)'(r2_p[m][2*c+1]) + CRND;
                w_sh[m][c] = w_df[m][c] >>> (C - 2);
                n3_l[NF+m][c] = w_sh[m][c][LW-1:0];
            end
        end
    end

    logic signed [LW-1:0] r3_l  [NA][3];
    logic signed [C-1:0]  r3_ax [NF][3];
    logic signed [DW-1:0] r3_d  [3];
    logic [C-1:0]         r3_h  [NF];
    logic                 r3_same;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r3_l    <= n3_l;
            r3_ax   <= r2_ax;
            r3_d    <= r2_d;
            r3_h    <= r2_h;
            r3_same <= r2_same;
        end
    end

    // stage 4: dot products
    logic signed [DDW-1:0] n4_dd [NA];
    logic signed [ADW-1:0] n4_ad [NA][NF];

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            n4_dd[a] = DDW'(r3_d[0] * r3_l[a][0]) + DDW'(r3_d[1] * r3_l[a][1])
                     + DDW'(r3_d[2] * r3_l[a][2]);
            for (int n = 0; n < NF; n++) begin
                n4_ad[a][n] = ADW'(r3_ax[n][0] * r3_l[a][0])
                            + ADW'(r3_ax[n][1] * r3_l[a][1])
                            + ADW'(r3_ax[n][2] * r3_l[a][2]);
            end
        end
    end

    logic signed [DDW-1:0] r4_dd [NA];
    logic signed [ADW-1:0] r4_ad [NA][NF];
    logic [C-1:0]          r4_h  [NF];
    logic                  r4_same;

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r4_dd   <= n4_dd;
            r4_ad   <= n4_ad;
            r4_h    <= r3_h;
            r4_same <= r3_same;
        end
    end

    // stage 5: magnitudes, round projections
    logic [DDW-1:0]     n5_dist [NA];
    logic [RW-1:0]      n5_rr   [NA][NF];
    logic signed [DDW:0] w_dx   [NA];
    logic signed [DDW:0] w_dm   [NA];
    logic signed [ADW:0] w_ax5  [NA][NF];
    logic [ADW:0]        w_am   [NA][NF];

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            w_dx[a]    = (DDW + 1)'(r4_dd[a]);
            w_dm[a]    = w_dx[a][DDW] ? -w_dx[a] : w_dx[a];
            n5_dist[a] = w_dm[a][DDW-1:0];
            for (int n = 0; n < NF; n++) begin
                w_ax5[a][n] = (ADW + 1)'(r4_ad[a][n]);
                w_am[a][n]  = (w_ax5[a][n][ADW] ? -w_ax5[a][n] : w_ax5[a][n]) + ARND;
                n5_rr[a][n] = w_am[a][n][C-2 +: RW];
            end
        end
    end

    logic [DDW-1:0] r5_dist [NA];
    logic [RW-1:0]  r5_rr   [NA][NF];
    logic [C-1:0]   r5_h    [NF];
    logic           r5_same;

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r5_dist <= n5_dist;
            r5_rr   <= n5_rr;
            r5_h    <= r4_h;
            r5_same <= r4_same;
        end
    end

    // stage 6: scale by half sizes
    logic [TW-1:0] n6_t [NA][NF];

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            for (int n = 0; n < NF; n++) begin
                n6_t[a][n] = TW'(r5_rr[a][n]) * TW'(r5_h[n]);
            end
        end
    end

    logic [TW-1:0]  r6_t    [NA][NF];
    logic [DDW-1:0] r6_dist [NA];
    logic           r6_same;

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r6_t    <= n6_t;
            r6_dist <= r5_dist;
            r6_same <= r5_same;
        end
    end

    // stage 7: radius sum and compare
    logic [NA-1:0] n7_sep;
    logic [SW-1:0] w_rad [NA];

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            w_rad[a] = '0;
            for (int n = 0; n < NF; n++) begin
                w_rad[a] = w_rad[a] + SW'(r6_t[a][n]);
            end
            n7_sep[a] = SW'(r6_dist[a]) > w_rad[a];
        end
    end

    logic [NA-1:0] r7_sep;
    logic          r7_same;

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r7_sep  <= n7_sep;
            r7_same <= r6_same;
        end
    end

    // stage 8: decide
    logic n8_ov;
    logic r8_ov;

    assign n8_ov = !(|r7_sep[NF-1:0]) && (r7_same || !(|r7_sep[NA-1:NF]));

    always_ff @(posedge i_clk) begin
        if (adv[NS]) begin
            r8_ov <= n8_ov;
        end
    end

    assign o_out.overlap = r8_ov;

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready && (&r_vld)))
        else $error("input stalled with a free stage");
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.ready |-> i_in.ready)
        else $error("input stalled while output drains");
    a_face_separates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[7] && adv[NS] && (|r7_sep[NF-1:0])) |=> !o_out.overlap)
        else $error("face axis separation lost");
    a_same_axis_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[7] && adv[NS] && r7_same && !(|r7_sep[NF-1:0])) |=> o_out.overlap)
        else $error("shared axis did not report overlap");
endmodule
